/* rtl/core/u2r_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2r_pkg
// Types and constants shared by the UYVY to RGB888 converter.
// ----------------------------------------------------------------------------
package u2r_pkg;

  localparam int FRAC    = 14;
  localparam int PROD_W  = 24;
  localparam int OFF_W   = 10;
  localparam int SUM_W   = 11;
  localparam int CFG_W   = 13;

  localparam logic [7:0]  CHROMA_BIAS = 8'd128;
  localparam logic [7:0]  PIX_MAX     = 8'd255;

  localparam logic signed [PROD_W-1:0] COEF_RV = 24'sd18678;
  localparam logic signed [PROD_W-1:0] COEF_GV = -24'sd9519;
  localparam logic signed [PROD_W-1:0] COEF_GU = -24'sd6472;
  localparam logic signed [PROD_W-1:0] COEF_BU = 24'sd33292;
  localparam logic signed [PROD_W-1:0] ROUND   = 24'sd8192;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd640;
  localparam logic [4:0]       SCALE_RST      = 5'd1;
  localparam logic [4:0]       SCALE_MAX      = 5'd16;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_SCALE      = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] u_in;
    logic [7:0] y0_in;
    logic [7:0] v_in;
    logic [7:0] y1_in;
  } macro_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_item;
    logic       end_of_line;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] r_off;
    logic signed [OFF_W-1:0] g_off;
    logic signed [OFF_W-1:0] b_off;
  } chroma_t;

  typedef struct packed {
    rgb_t pix0;
    rgb_t pix1;
    logic two;
    logic eol;
  } pair_t;

  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > $signed({3'b000, PIX_MAX})) begin
      r = PIX_MAX;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/u2r_chroma.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2r_chroma
// Registered chroma products and their rounded Q14 offsets, shared by lanes.
// ----------------------------------------------------------------------------
module u2r_chroma import u2r_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [8:0]     u,
  input  logic signed [8:0]     v,
  output chroma_t               offs
);

  logic signed [PROD_W-1:0] u_x, v_x;
  logic signed [PROD_W-1:0] pr, pgv, pgu, pb;
  logic signed [PROD_W-1:0] sum_r, sum_g, sum_b;

  assign u_x = PROD_W'(u);
  assign v_x = PROD_W'(v);

  always_ff @(posedge clk) begin
    if (en) begin
      pr  <= v_x * COEF_RV;
      pgv <= v_x * COEF_GV;
      pgu <= u_x * COEF_GU;
      pb  <= u_x * COEF_BU;
    end
  end

  always_comb begin
    sum_r = pr + ROUND;
    sum_g = pgv + pgu + ROUND;
    sum_b = pb + ROUND;
    offs.r_off = OFF_W'(sum_r >>> FRAC);
    offs.g_off = OFF_W'(sum_g >>> FRAC);
    offs.b_off = OFF_W'(sum_b >>> FRAC);
  end

endmodule

/* rtl/core/u2r_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2r_lane
// One pixel lane: adds luma to the chroma offsets and clamps to 0..255.
// ----------------------------------------------------------------------------
module u2r_lane import u2r_pkg::*; (
  input  logic [7:0] y,
  input  chroma_t    offs,
  output rgb_t       px
);

  logic signed [SUM_W-1:0] y_x, r_s, g_s, b_s;

  always_comb begin
    y_x = $signed({3'b000, y});
    r_s = y_x + $signed({offs.r_off[OFF_W-1], offs.r_off});
    g_s = y_x + $signed({offs.g_off[OFF_W-1], offs.g_off});
    b_s = y_x + $signed({offs.b_off[OFF_W-1], offs.b_off});
    px.red   = clamp8(r_s);
    px.green = clamp8(g_s);
    px.blue  = clamp8(b_s);
  end

endmodule

/* rtl/core/u2r_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2r_merge
// Merges the lane results into a two-entry pixel buffer and sends one pixel
// per transfer.
// ----------------------------------------------------------------------------
module u2r_merge import u2r_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  pair_t  pair,
  output logic   ready,
  output logic   pixel_valid,
  input  logic   pixel_stall,
  output pixel_t pixel_data
);

  pixel_t     head, tail;
  logic [1:0] cnt;
  logic       take;

  assign pixel_valid = (cnt != 2'd0);
  assign pixel_data  = head;
  assign take        = pixel_valid && !pixel_stall;
  assign ready       = (cnt == 2'd0) || (cnt == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= pair.two ? 2'd2 : 2'd1;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pair.two) begin
        head <= '{red: pair.pix0.red, green: pair.pix0.green, blue: pair.pix0.blue,
                  last_of_item: 1'b0, end_of_line: 1'b0};
        tail <= '{red: pair.pix1.red, green: pair.pix1.green, blue: pair.pix1.blue,
                  last_of_item: 1'b1, end_of_line: pair.eol};
      end else begin
        head <= '{red: pair.pix0.red, green: pair.pix0.green, blue: pair.pix0.blue,
                  last_of_item: 1'b1, end_of_line: pair.eol};
      end
    end else if (take && cnt == 2'd2) begin
      head <= tail;
    end
  end

endmodule

/* rtl/core/uyvy_to_rgb_decimating_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uyvy_to_rgb_decimating_unit
// UYVY macropixel to RGB888 converter with optional decimation on both axes.
// ----------------------------------------------------------------------------
// One macropixel enters per transfer on the macro channel; RGB pixels leave one
// per transfer on the pixel channel. At scale 1 each macropixel gives two
// pixels, so the sustained rate is set by the single pixel output port; when
// decimating, kept macropixels give one pixel and a macropixel is taken every
// cycle while the pixel channel is not stalled. The first pixel of an input
// transfer passes the input register, chroma multipliers and pixel buffer.
// Configuration writes are taken in any cycle but must be made while idle.
// ----------------------------------------------------------------------------
module uyvy_to_rgb_decimating_unit import u2r_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             macro_valid,
  output logic             macro_stall,
  input  macro_t           macro_data,
  output logic             pixel_valid,
  input  logic             pixel_stall,
  output pixel_t           pixel_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  reg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int HALF_MAX = MAX_LINE_WIDTH / 2;
  localparam int MW = $clog2(HALF_MAX + 1);
  localparam int CW = (HALF_MAX > 2) ? $clog2(HALF_MAX) : 1;

  logic [CFG_W-1:0] line_width;
  logic [4:0]       scale;

  logic [CW-1:0]    column_index;
  logic [3:0]       row_phase;
  logic [2:0]       col_mod [0:7];

  logic [MW-1:0]    m;
  logic [4:0]       s_eff;
  logic [3:0]       half;
  logic [2:0]       half_idx;
  logic             scale_one, line_end, keep, in_take, col_hit;
  logic             eol_next;

  logic             a_valid, a_two, a_eol;
  logic signed [8:0] a_u, a_v;
  logic [7:0]       a_y0, a_y1;
  logic             b_valid, b_two, b_eol;
  logic [7:0]       b_y0, b_y1;
  logic             a_move, a_free, b_free, m_rdy, load;
  chroma_t          offs;
  rgb_t             px0, px1;
  pair_t            pair;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      scale      <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data;
        REG_SCALE:      scale      <= cfg_data[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    if (32'(line_width >> 1) > HALF_MAX) begin
      m = MW'(HALF_MAX);
    end else begin
      m = MW'(line_width >> 1);
    end
    if (m == '0) begin
      m = MW'(1);
    end

    if (scale == 5'd0) begin
      s_eff = 5'd1;
    end else if (scale > SCALE_MAX) begin
      s_eff = SCALE_MAX;
    end else if (scale > 5'd1) begin
      s_eff = {scale[4:1], 1'b0};
    end else begin
      s_eff = scale;
    end
    scale_one = (s_eff == 5'd1);
    half      = s_eff[4:1];
    half_idx  = 3'(half - 4'd1);

    line_end = (32'(column_index) + 32'd1) >= 32'(m);
    col_hit  = (col_mod[half_idx] == 3'd0);
    keep     = scale_one || (row_phase == 4'd0 && col_hit);
    eol_next = scale_one ? line_end : ((32'(column_index) + 32'(half)) >= 32'(m));
  end

  // pipeline flow
  assign b_free      = !b_valid || m_rdy;
  assign a_free      = !a_valid || b_free;
  assign a_move      = a_valid && b_free;
  assign load        = b_valid && m_rdy;
  assign macro_stall = !a_free;
  assign in_take     = macro_valid && !macro_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_phase    <= '0;
      for (int h = 0; h < 8; h++) begin
        col_mod[h] <= '0;
      end
    end else if (in_take) begin
      if (line_end) begin
        column_index <= '0;
        for (int h = 0; h < 8; h++) begin
          col_mod[h] <= '0;
        end
        if (scale_one || (5'(row_phase) + 5'd1) >= s_eff) begin
          row_phase <= '0;
        end else begin
          row_phase <= row_phase + 4'd1;
        end
      end else begin
        column_index <= column_index + CW'(1);
        for (int h = 0; h < 8; h++) begin
          col_mod[h] <= (col_mod[h] == 3'(h)) ? 3'd0 : col_mod[h] + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_take && keep;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && keep && a_free) begin
      a_u   <= $signed({1'b0, macro_data.u_in}) - $signed({1'b0, CHROMA_BIAS});
      a_v   <= $signed({1'b0, macro_data.v_in}) - $signed({1'b0, CHROMA_BIAS});
      a_y0  <= macro_data.y0_in;
      a_y1  <= macro_data.y1_in;
      a_two <= scale_one;
      a_eol <= eol_next;
    end
    if (a_move) begin
      b_y0  <= a_y0;
      b_y1  <= a_y1;
      b_two <= a_two;
      b_eol <= a_eol;
    end
  end

  u2r_chroma u_chroma (
    .clk  (clk),
    .en   (a_move),
    .u    (a_u),
    .v    (a_v),
    .offs (offs)
  );

  u2r_lane u_lane0 (
    .y    (b_y0),
    .offs (offs),
    .px   (px0)
  );

  u2r_lane u_lane1 (
    .y    (b_y1),
    .offs (offs),
    .px   (px1)
  );

  assign pair = '{pix0: px0, pix1: px1, two: b_two, eol: b_eol};

  u2r_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .pair        (pair),
    .ready       (m_rdy),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_data  (pixel_data)
  );

  a_move_fills_b: assert property (@(posedge clk) disable iff (rst)
    a_move |=> b_valid)
    else $error("chroma stage lost an item");

  b_holds_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !m_rdy) |=> (b_valid && $stable(b_two) && $stable(b_eol)))
    else $error("chroma stage changed while blocked");

  eol_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_data.last_of_item) |-> !pixel_data.end_of_line)
    else $error("line end flagged on a non-final pixel");

endmodule

/* bench/uyvy_to_rgb_decimating_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uyvy_to_rgb_decimating_unit_tb
// Self-checking bench for the UYVY to RGB888 converter with decimation.
// A directed table covers the colour extremes, line width and scale corner
// values and counters left out of range by register writes. Random phases
// then follow with new line widths and scales. Every accepted macropixel is
// run through a local conversion and decimation predictor, and each pixel
// transfer is compared field by field with the oldest expected pixel. Both
// channels idle at random, with some stretches held at full rate.
// ----------------------------------------------------------------------------
module uyvy_to_rgb_decimating_unit_tb;
  import u2r_pkg::*;

  localparam int MAX_W      = 4096;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 8;
  localparam int END_WAIT   = 20;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 40;
  localparam int K_RV       = 18678;
  localparam int K_GV       = -9519;
  localparam int K_GU       = 6472;
  localparam int K_BU       = 33292;
  localparam int K_RND      = 8192;

  typedef struct {
    bit               is_reg;
    reg_index_t       idx;
    logic [CFG_W-1:0] val;
    macro_t           mp;
    bit               known;
    pixel_t           p0;
    pixel_t           p1;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             macro_valid;
  logic             macro_stall;
  macro_t           macro_data;
  logic             pixel_valid;
  logic             pixel_stall;
  pixel_t           pixel_data;
  logic             cfg_valid;
  logic             cfg_ready;
  reg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pixel_t           expected_pixels[$];
  dir_row_t         directed[$];
  logic [CFG_W-1:0] width_q;
  logic [4:0]       scale_q;
  logic [10:0]      column_q;
  logic [3:0]       row_phase_q;
  bit               steady;
  int               cycles;
  int               mismatches;
  int               pixels_checked;
  int               macros_sent;
  int               reg_writes;

  uyvy_to_rgb_decimating_unit DUT (
    .clk(clk),
    .rst(rst),
    .macro_valid(macro_valid),
    .macro_stall(macro_stall),
    .macro_data(macro_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_data(pixel_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait();
    if (steady || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [7:0] sat8(input int x);
    if (x < 0) begin
      return 8'd0;
    end
    if (x > 255) begin
      return 8'd255;
    end
    return x[7:0];
  endfunction

  function automatic pixel_t to_pixel(input int y, input int u, input int v,
                                      input bit last, input bit eol);
    pixel_t p;
    p.red          = sat8(y + ((K_RV * v + K_RND) >>> 14));
    p.green        = sat8(y + ((K_GV * v - K_GU * u + K_RND) >>> 14));
    p.blue         = sat8(y + ((K_BU * u + K_RND) >>> 14));
    p.last_of_item = last;
    p.end_of_line  = eol;
    return p;
  endfunction

  // Advances the column and row counters; records the pixels that leave when record is set.
  function automatic void convert_macro(input macro_t mp, input bit record);
    int w;
    int s;
    int m;
    int half;
    int u;
    int v;
    int c;
    bit line_end;
    w = width_q;
    if (w > MAX_W) begin
      w = MAX_W;
    end
    m = w / 2;
    if (m == 0) begin
      m = 1;
    end
    s = scale_q;
    if (s == 0) begin
      s = 1;
    end
    if (s > 16) begin
      s = 16;
    end
    if (s > 1) begin
      s = s & ~1;
    end
    half = s / 2;
    u = int'(mp.u_in) - 128;
    v = int'(mp.v_in) - 128;
    c = column_q;
    line_end = (c + 1 >= m);
    if (record) begin
      if (s == 1) begin
        expected_pixels.push_back(to_pixel(mp.y0_in, u, v, 1'b0, 1'b0));
        expected_pixels.push_back(to_pixel(mp.y1_in, u, v, 1'b1, line_end));
      end else if (row_phase_q == 0 && c % half == 0) begin
        expected_pixels.push_back(to_pixel(mp.y0_in, u, v, 1'b1, c + half >= m));
      end
    end
    if (line_end) begin
      column_q = '0;
      if (s == 1 || row_phase_q + 1 >= s) begin
        row_phase_q = '0;
      end else begin
        row_phase_q = row_phase_q + 1'b1;
      end
    end else begin
      column_q = column_q + 1'b1;
    end
  endfunction

  function automatic dir_row_t reg_row(input reg_index_t idx, input int val);
    dir_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val[CFG_W-1:0];
    r.mp     = '0;
    r.known  = 1'b0;
    r.p0     = '0;
    r.p1     = '0;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [7:0] u, input logic [7:0] y0,
                                        input logic [7:0] v, input logic [7:0] y1);
    dir_row_t r;
    r.is_reg = 1'b0;
    r.idx    = REG_LINE_WIDTH;
    r.val    = '0;
    r.mp     = '{u, y0, v, y1};
    r.known  = 1'b0;
    r.p0     = '0;
    r.p1     = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [7:0] u, input logic [7:0] y0,
                                         input logic [7:0] v, input logic [7:0] y1,
                                         input pixel_t p0, input pixel_t p1);
    dir_row_t r;
    r       = item_row(u, y0, v, y1);
    r.known = 1'b1;
    r.p0    = p0;
    r.p1    = p1;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  task automatic send_macro(input macro_t mp, input bit record);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      macro_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    macro_valid <= 1'b1;
    macro_data  <= mp;
    @(posedge clk);
    while (macro_stall) @(posedge clk);
    convert_macro(mp, record);
    macros_sent++;
    @(negedge clk);
  endtask

  // Registers change only once every expected pixel has left and the
  // pipeline has had time to flush dropped macropixels.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    macro_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LINE_WIDTH) begin
      width_q = val;
    end else begin
      scale_q = val[4:0];
    end
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycles, expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (expected_pixels.size() == 0) begin
        log_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b eol=%0b",
                               pixel_data.red, pixel_data.green, pixel_data.blue,
                               pixel_data.last_of_item, pixel_data.end_of_line));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_data.red !== want.red || pixel_data.green !== want.green ||
            pixel_data.blue !== want.blue ||
            pixel_data.last_of_item !== want.last_of_item ||
            pixel_data.end_of_line !== want.end_of_line) begin
          log_mismatch($sformatf(
            "pixel %0d: expected r=%0d g=%0d b=%0d last=%0b eol=%0b, got r=%0d g=%0d b=%0d last=%0b eol=%0b",
            pixels_checked, want.red, want.green, want.blue, want.last_of_item,
            want.end_of_line, pixel_data.red, pixel_data.green, pixel_data.blue,
            pixel_data.last_of_item, pixel_data.end_of_line));
        end
      end
    end
  end

  initial begin : pixel_sink
    int gap;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        pixel_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        pixel_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(pixel_valid && !pixel_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int               ph;
    int               n;
    int               w;
    int               s;
    logic [CFG_W-1:0] d;
    macro_t           mp;
    rst            = 1'b1;
    macro_valid    = 1'b0;
    macro_data     = '0;
    pixel_stall    = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_LINE_WIDTH;
    cfg_data       = '0;
    steady         = 1'b0;
    cycles         = 0;
    mismatches     = 0;
    pixels_checked = 0;
    macros_sent    = 0;
    reg_writes     = 0;
    width_q        = 13'd640;
    scale_q        = 5'd1;
    column_q       = '0;
    row_phase_q    = '0;

    // neutral chroma, then both chroma extremes, at reset settings
    directed.push_back(known_row(8'd128, 8'd0, 8'd128, 8'd255,
                                 pixel_t'{8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
                                 pixel_t'{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}));
    directed.push_back(known_row(8'd0, 8'd0, 8'd0, 8'd255,
                                 pixel_t'{8'd0, 8'd125, 8'd0, 1'b0, 1'b0},
                                 pixel_t'{8'd109, 8'd255, 8'd0, 1'b1, 1'b0}));
    directed.push_back(known_row(8'd255, 8'd0, 8'd255, 8'd255,
                                 pixel_t'{8'd145, 8'd0, 8'd255, 1'b0, 1'b0},
                                 pixel_t'{8'd255, 8'd131, 8'd255, 1'b1, 1'b0}));
    // one macropixel per line; column left beyond the end
    directed.push_back(reg_row(REG_LINE_WIDTH, 2));
    directed.push_back(known_row(8'd128, 8'd10, 8'd128, 8'd20,
                                 pixel_t'{8'd10, 8'd10, 8'd10, 1'b0, 1'b0},
                                 pixel_t'{8'd20, 8'd20, 8'd20, 1'b1, 1'b1}));
    // odd width
    directed.push_back(reg_row(REG_LINE_WIDTH, 7));
    directed.push_back(item_row(8'h55, 8'hAA, 8'h33, 8'hCC));
    directed.push_back(item_row(8'hAA, 8'h55, 8'hCC, 8'h33));
    directed.push_back(item_row(8'h0F, 8'hF0, 8'hF0, 8'h0F));
    // widths below one macropixel
    directed.push_back(reg_row(REG_LINE_WIDTH, 0));
    directed.push_back(item_row(8'h80, 8'h7F, 8'h7F, 8'h80));
    directed.push_back(reg_row(REG_LINE_WIDTH, 1));
    directed.push_back(item_row(8'h01, 8'hFE, 8'hFE, 8'h01));
    // width beyond the maximum, then shrunk under the column
    directed.push_back(reg_row(REG_LINE_WIDTH, 8191));
    directed.push_back(item_row(8'h10, 8'h20, 8'h30, 8'h40));
    directed.push_back(item_row(8'hC0, 8'hD0, 8'hE0, 8'hF0));
    directed.push_back(item_row(8'h7F, 8'hFF, 8'h00, 8'h00));
    directed.push_back(reg_row(REG_LINE_WIDTH, 4));
    directed.push_back(item_row(8'h00, 8'hFF, 8'hFF, 8'h00));
    // scale zero, odd scale
    directed.push_back(reg_row(REG_SCALE, 0));
    directed.push_back(item_row(8'h90, 8'h60, 8'h70, 8'hA0));
    directed.push_back(reg_row(REG_SCALE, 3));
    directed.push_back(item_row(8'h22, 8'h44, 8'h66, 8'h88));
    directed.push_back(item_row(8'h99, 8'hBB, 8'hDD, 8'hEE));
    directed.push_back(item_row(8'h11, 8'h33, 8'h55, 8'h77));
    directed.push_back(item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // scale above the maximum; row phase then left beyond a smaller scale
    directed.push_back(reg_row(REG_SCALE, 31));
    directed.push_back(reg_row(REG_LINE_WIDTH, 2));
    directed.push_back(item_row(8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(item_row(8'h40, 8'h50, 8'h60, 8'h70));
    directed.push_back(item_row(8'h41, 8'h51, 8'h61, 8'h71));
    directed.push_back(item_row(8'h42, 8'h52, 8'h62, 8'h72));
    directed.push_back(item_row(8'h43, 8'h53, 8'h63, 8'h73));
    directed.push_back(reg_row(REG_SCALE, 13'h1FE4));
    directed.push_back(item_row(8'hB0, 8'hB1, 8'hB2, 8'hB3));
    directed.push_back(item_row(8'h3C, 8'hC3, 8'h5A, 8'hA5));

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        if (directed[i].known) begin
          expected_pixels.push_back(directed[i].p0);
          expected_pixels.push_back(directed[i].p1);
        end
        send_macro(directed[i].mp, !directed[i].known);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 3 == 2);
      case (ph)
        0: begin
          w = 2;
          s = 1;
        end
        1: begin
          w = 4096;
          s = 1;
        end
        2: begin
          w = 2;
          s = 16;
        end
        3: begin
          w = 8190;
          s = 2;
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            w = $urandom_range(0, 8191);
          end else begin
            w = 2 * $urandom_range(1, 24);
          end
          if ($urandom_range(0, 4) == 0) begin
            s = $urandom_range(0, 31);
          end else begin
            n = $urandom_range(0, 8);
            s = (n == 0) ? 1 : 2 * n;
          end
        end
      endcase
      write_reg(REG_LINE_WIDTH, w[CFG_W-1:0]);
      d      = CFG_W'($urandom);
      d[4:0] = s[4:0];
      write_reg(REG_SCALE, d);
      for (n = 0; n < PHASE_LEN; n++) begin
        mp = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_macro(mp, 1'b1);
      end
    end

    steady = 1'b0;
    macro_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);

    $display("%0d macropixels converted, %0d pixels compared, %0d register writes",
             macros_sent, pixels_checked, reg_writes);
    $display("widths 0 to 8191 and scales 0 to 31 seen, with random idling on both sides");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* uyvy_to_rgb_decimating_unit.f */
rtl/core/u2r_pkg.sv
rtl/core/u2r_chroma.sv
rtl/core/u2r_lane.sv
rtl/core/u2r_merge.sv
rtl/core/uyvy_to_rgb_decimating_unit.sv
bench/uyvy_to_rgb_decimating_unit_tb.sv
